// ===== hdl/rfrd_pkg.sv =====
// ---------------------------------------------------------------------------
// rfrd_pkg
// Shared types and constants for the rotated framebuffer rectangle
// descriptor generator.
// ---------------------------------------------------------------------------
package rfrd_pkg;

   localparam int COORD_BITS      = 12;
   localparam int BYTES_PER_PIXEL = 2;
   localparam int BPP_SHIFT       = $clog2(BYTES_PER_PIXEL);

   localparam int LINE_BITS   = COORD_BITS + 1;
   localparam int PROD_BITS   = COORD_BITS + LINE_BITS;
   localparam int IDX_BITS    = PROD_BITS + 1;
   localparam int ADDR_BITS   = 32;
   localparam int ASUM_BITS   = (IDX_BITS + BPP_SHIFT > ADDR_BITS) ?
                                (IDX_BITS + BPP_SHIFT) : ADDR_BITS;
   localparam int COLOR_BITS  = 24;
   localparam int C565_BITS   = 16;
   localparam int AMIN_BITS   = 24;
   localparam int AREA_BITS   = 2 * COORD_BITS;
   localparam int ACMP_BITS   = (AREA_BITS > AMIN_BITS) ? AREA_BITS : AMIN_BITS;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ORIENTATION    = 3'd0,
      CSR_FRAME_BASE     = 3'd1,
      CSR_X_RESOLUTION   = 3'd2,
      CSR_Y_RESOLUTION   = 3'd3,
      CSR_LINE_PAD       = 3'd4,
      CSR_ACCEL_MIN_AREA = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ROT_0   = 2'd0,
      ROT_90  = 2'd1,
      ROT_180 = 2'd2,
      ROT_270 = 2'd3
   } rotation_type;

   typedef struct packed {
      rotation_type            orientation;
      logic [ADDR_BITS-1:0]    frame_base;
      logic [COORD_BITS-1:0]   x_resolution;
      logic [COORD_BITS-1:0]   y_resolution;
      logic [COORD_BITS-1:0]   line_pad;
      logic [AMIN_BITS-1:0]    accel_min_area;
   } cfg_type;

   localparam rotation_type          RST_ORIENTATION    = ROT_90;
   localparam logic [ADDR_BITS-1:0]  RST_FRAME_BASE     = '0;
   localparam logic [COORD_BITS-1:0] RST_X_RESOLUTION   = COORD_BITS'(768);
   localparam logic [COORD_BITS-1:0] RST_Y_RESOLUTION   = COORD_BITS'(1366);
   localparam logic [COORD_BITS-1:0] RST_LINE_PAD       = COORD_BITS'(10);
   localparam logic [AMIN_BITS-1:0]  RST_ACCEL_MIN_AREA = AMIN_BITS'(50);

   function automatic logic [C565_BITS-1:0] pack_565(input logic [COLOR_BITS-1:0] c);
      pack_565 = {c[23:19], c[15:10], c[7:3]};
   endfunction

endpackage

// ===== hdl/rfrd_csr.sv =====
// ---------------------------------------------------------------------------
// rfrd_csr
// Configuration register file; takes one write beat per cycle.
// ---------------------------------------------------------------------------
module rfrd_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rfrd_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [rfrd_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output rfrd_pkg::cfg_type                     cfg
);

   rfrd_pkg::cfg_type cfg_ff;
   rfrd_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (rfrd_pkg::csr_index_type'(csr_index))
            rfrd_pkg::CSR_ORIENTATION:
               cfg_in.orientation = rfrd_pkg::rotation_type'(csr_wdata[1:0]);
            rfrd_pkg::CSR_FRAME_BASE:
               cfg_in.frame_base = csr_wdata[rfrd_pkg::ADDR_BITS-1:0];
            rfrd_pkg::CSR_X_RESOLUTION:
               cfg_in.x_resolution = csr_wdata[rfrd_pkg::COORD_BITS-1:0];
            rfrd_pkg::CSR_Y_RESOLUTION:
               cfg_in.y_resolution = csr_wdata[rfrd_pkg::COORD_BITS-1:0];
            rfrd_pkg::CSR_LINE_PAD:
               cfg_in.line_pad = csr_wdata[rfrd_pkg::COORD_BITS-1:0];
            rfrd_pkg::CSR_ACCEL_MIN_AREA:
               cfg_in.accel_min_area = csr_wdata[rfrd_pkg::AMIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.orientation    <= rfrd_pkg::RST_ORIENTATION;
         cfg_ff.frame_base     <= rfrd_pkg::RST_FRAME_BASE;
         cfg_ff.x_resolution   <= rfrd_pkg::RST_X_RESOLUTION;
         cfg_ff.y_resolution   <= rfrd_pkg::RST_Y_RESOLUTION;
         cfg_ff.line_pad       <= rfrd_pkg::RST_LINE_PAD;
         cfg_ff.accel_min_area <= rfrd_pkg::RST_ACCEL_MIN_AREA;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/rotated_framebuffer_rect_descriptor.sv =====
// ---------------------------------------------------------------------------
// rotated_framebuffer_rect_descriptor
// Maps a logical rectangle into a rotated, padded framebuffer and emits a
// 2D-transfer descriptor with the RGB565 fill color.
// ---------------------------------------------------------------------------
//
//   channel | ports                          | handshake
//   --------+--------------------------------+-------------------------------
//   request | start, busy, req_*             | beat taken when start & !busy
//   result  | rsp_valid, rsp_*               | one-cycle strobe, no back-pressure
//   config  | csr_valid, csr_ready, csr_*    | beat taken when valid & ready
//
// One request per cycle; each result passes through the stage 1, 2 and 3 registers.
// Stage 1 checks bounds and picks row/column terms for the rotation, stage 2
// holds the two multipliers (row times line pitch, width times height),
// stage 3 adds the column and frame base and compares the area.
// Reset is synchronous, clears the valid bits and loads the configuration
// registers with their reset values.
// busy stays low: the result side never stalls, so nothing backs up.
// ---------------------------------------------------------------------------
module rotated_framebuffer_rect_descriptor (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [rfrd_pkg::COORD_BITS-1:0]       req_rect_x,
   input  logic [rfrd_pkg::COORD_BITS-1:0]       req_rect_y,
   input  logic [rfrd_pkg::COORD_BITS-1:0]       req_rect_width,
   input  logic [rfrd_pkg::COORD_BITS-1:0]       req_rect_height,
   input  logic [rfrd_pkg::COLOR_BITS-1:0]       req_fill_color,
   output logic                                  rsp_valid,
   output logic [rfrd_pkg::ADDR_BITS-1:0]        rsp_start_address,
   output logic [rfrd_pkg::COORD_BITS-1:0]       rsp_run_length,
   output logic [rfrd_pkg::COORD_BITS-1:0]       rsp_run_count,
   output logic [rfrd_pkg::LINE_BITS-1:0]        rsp_line_skip,
   output logic [rfrd_pkg::C565_BITS-1:0]        rsp_color_565,
   output logic                                  rsp_use_accelerator,
   output logic                                  rsp_range_error,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rfrd_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [rfrd_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int CB = rfrd_pkg::COORD_BITS;
   localparam int LB = rfrd_pkg::LINE_BITS;

   rfrd_pkg::cfg_type cfg;

   rfrd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign busy = 1'b0;

   // ---------------- stage 1: bounds and rotation terms ----------------
   logic                 accept;
   logic [CB:0]          x_end, y_end, x_rem, y_rem;
   logic                 bad_in;
   logic [CB-1:0]        row_in, col_in, run_in, runs_in;
   logic [LB-1:0]        line_in;

   assign accept = start & ~busy;

   always_comb begin
      x_end  = {1'b0, req_rect_x} + {1'b0, req_rect_width};
      y_end  = {1'b0, req_rect_y} + {1'b0, req_rect_height};
      x_rem  = {1'b0, cfg.x_resolution} - x_end;
      y_rem  = {1'b0, cfg.y_resolution} - y_end;
      bad_in = (req_rect_width == '0) || (req_rect_height == '0) ||
               (x_end > {1'b0, cfg.x_resolution}) ||
               (y_end > {1'b0, cfg.y_resolution});
      case (cfg.orientation)
         rfrd_pkg::ROT_0: begin
            line_in = {1'b0, cfg.x_resolution} + {1'b0, cfg.line_pad};
            run_in  = req_rect_width;
            runs_in = req_rect_height;
            row_in  = req_rect_y;
            col_in  = req_rect_x;
         end
         rfrd_pkg::ROT_90: begin
            line_in = {1'b0, cfg.y_resolution} + {1'b0, cfg.line_pad};
            run_in  = req_rect_height;
            runs_in = req_rect_width;
            row_in  = x_rem[CB-1:0];
            col_in  = req_rect_y;
         end
         rfrd_pkg::ROT_180: begin
            line_in = {1'b0, cfg.x_resolution} + {1'b0, cfg.line_pad};
            run_in  = req_rect_width;
            runs_in = req_rect_height;
            row_in  = y_rem[CB-1:0];
            col_in  = x_rem[CB-1:0];
         end
         default: begin
            line_in = {1'b0, cfg.y_resolution} + {1'b0, cfg.line_pad};
            run_in  = req_rect_height;
            runs_in = req_rect_width;
            row_in  = req_rect_x;
            col_in  = y_rem[CB-1:0];
         end
      endcase
   end

   logic                               s1_valid_ff;
   logic                               s1_bad_ff;
   logic [CB-1:0]                      s1_row_ff, s1_col_ff, s1_run_ff, s1_runs_ff;
   logic [CB-1:0]                      s1_w_ff, s1_h_ff;
   logic [LB-1:0]                      s1_line_ff;
   logic [rfrd_pkg::C565_BITS-1:0]     s1_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_bad_ff   <= bad_in;
      s1_row_ff   <= row_in;
      s1_col_ff   <= col_in;
      s1_run_ff   <= run_in;
      s1_runs_ff  <= runs_in;
      s1_w_ff     <= req_rect_width;
      s1_h_ff     <= req_rect_height;
      s1_line_ff  <= line_in;
      s1_color_ff <= rfrd_pkg::pack_565(req_fill_color);
   end

   // ---------------- stage 2: multipliers ----------------
   logic                                s2_valid_ff;
   logic                                s2_bad_ff;
   logic [rfrd_pkg::PROD_BITS-1:0]      s2_prod_ff;
   logic [rfrd_pkg::AREA_BITS-1:0]      s2_area_ff;
   logic [CB-1:0]                       s2_col_ff, s2_run_ff, s2_runs_ff;
   logic [LB-1:0]                       s2_skip_ff;
   logic [rfrd_pkg::C565_BITS-1:0]      s2_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_bad_ff   <= s1_bad_ff;
      s2_prod_ff  <= rfrd_pkg::PROD_BITS'(s1_row_ff) * rfrd_pkg::PROD_BITS'(s1_line_ff);
      s2_area_ff  <= rfrd_pkg::AREA_BITS'(s1_w_ff) * rfrd_pkg::AREA_BITS'(s1_h_ff);
      s2_col_ff   <= s1_col_ff;
      s2_run_ff   <= s1_run_ff;
      s2_runs_ff  <= s1_runs_ff;
      s2_skip_ff  <= s1_line_ff - {1'b0, s1_run_ff};
      s2_color_ff <= s1_color_ff;
   end

   // ---------------- stage 3: address and area compare ----------------
   logic [rfrd_pkg::IDX_BITS-1:0]   idx;
   logic [rfrd_pkg::ASUM_BITS-1:0]  addr_sum;
   logic                            accel;

   always_comb begin
      idx      = {1'b0, s2_prod_ff} + rfrd_pkg::IDX_BITS'(s2_col_ff);
      addr_sum = (rfrd_pkg::ASUM_BITS'(idx) << rfrd_pkg::BPP_SHIFT) +
                 rfrd_pkg::ASUM_BITS'(cfg.frame_base);
      accel    = rfrd_pkg::ACMP_BITS'(s2_area_ff) >
                 rfrd_pkg::ACMP_BITS'(cfg.accel_min_area);
   end

   logic                                s3_valid_ff;
   logic [rfrd_pkg::ADDR_BITS-1:0]      s3_addr_ff;
   logic [CB-1:0]                       s3_run_ff, s3_runs_ff;
   logic [LB-1:0]                       s3_skip_ff;
   logic [rfrd_pkg::C565_BITS-1:0]      s3_color_ff;
   logic                                s3_accel_ff;
   logic                                s3_bad_ff;

   // zero the descriptor fields of an out-of-frame or empty rectangle, keep the color
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_addr_ff  <= s2_bad_ff ? '0 : addr_sum[rfrd_pkg::ADDR_BITS-1:0];
      s3_run_ff   <= s2_bad_ff ? '0 : s2_run_ff;
      s3_runs_ff  <= s2_bad_ff ? '0 : s2_runs_ff;
      s3_skip_ff  <= s2_bad_ff ? '0 : s2_skip_ff;
      s3_accel_ff <= s2_bad_ff ? 1'b0 : accel;
      s3_bad_ff   <= s2_bad_ff;
      s3_color_ff <= s2_color_ff;
   end

   assign rsp_valid           = s3_valid_ff;
   assign rsp_start_address   = s3_addr_ff;
   assign rsp_run_length      = s3_run_ff;
   assign rsp_run_count       = s3_runs_ff;
   assign rsp_line_skip       = s3_skip_ff;
   assign rsp_color_565       = s3_color_ff;
   assign rsp_use_accelerator = s3_accel_ff;
   assign rsp_range_error     = s3_bad_ff;

endmodule
